@@ hw/rtl/gef_pkg.sv @@
// Shared constants, codes and types of the GPIO edge-event ring.
package gef_pkg;

    localparam int RING_DEPTH  = 512;
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int LINE_COUNT  = 64;
    localparam int MAX_BURST   = 64;
    localparam int LINE_W      = 6;
    localparam int STAMP_W     = 32;
    localparam int CNT_W       = 7;
    localparam int MASK_W      = 64;
    localparam int APB_ADDR_W  = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 2;

    localparam logic [1:0] MODE_EDGE = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    localparam logic REG_RISE_MASK = 1'b0;
    localparam logic REG_FALL_MASK = 1'b1;

    typedef struct packed {
        logic               is_read;
        logic [STAMP_W-1:0] stamp;
        logic [LINE_W-1:0]  line;
        logic               level;
        logic [CNT_W-1:0]   count;
    } gef_cmd_t;

    typedef struct packed {
        logic               level;
        logic [LINE_W-1:0]  line;
        logic [STAMP_W-1:0] stamp;
    } gef_entry_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [STAMP_W-1:0] stamp;
        logic [LINE_W-1:0]  line;
        logic               level;
        logic               last;
        logic               more;
    } gef_res_t;

    typedef struct packed {
        logic     valid;
        gef_cmd_t cmd;
    } gef_cmd_push_t;

endpackage

@@ hw/rtl/gef_if.sv @@
// Stream interfaces for input items and result words.
interface gef_item_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  mode;
    logic [gef_pkg::LINE_W-1:0]  pin_index;
    logic                        pin_level;
    logic [gef_pkg::CNT_W-1:0]   read_count;

    modport source (output valid, mode, pin_index, pin_level, read_count, input ready);
    modport sink   (input valid, mode, pin_index, pin_level, read_count, output ready);
endinterface

interface gef_result_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [gef_pkg::STAMP_W-1:0] stamp;
    logic [gef_pkg::LINE_W-1:0]  event_line;
    logic                        edge_dir;
    logic                        event_level;
    logic                        last;
    logic                        more_pending;

    modport source (output valid, status, stamp, event_line, edge_dir, event_level, last,
                    more_pending, input ready);
    modport sink   (input valid, status, stamp, event_line, edge_dir, event_level, last,
                    more_pending, output ready);
endinterface

@@ hw/rtl/gef_front.sv @@
// Front end: accept items, keep the microsecond counter and arm masks, classify edges.
module gef_front (
    input  logic                             clk,
    input  logic                             rst_n,
    gef_item_if.sink                         item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gef_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [gef_pkg::MASK_W-1:0]       pwdata,
    output logic [gef_pkg::MASK_W-1:0]       prdata,
    output logic                             pready,
    input  logic                             queue_full,
    output gef_pkg::gef_cmd_push_t           push
);

    logic [gef_pkg::MASK_W-1:0]  rise_mask_reg, rise_mask_next;
    logic [gef_pkg::MASK_W-1:0]  fall_mask_reg, fall_mask_next;
    logic [gef_pkg::STAMP_W-1:0] usec_reg, usec_next;
    logic                        accept;
    logic                        cfg_write;
    logic                        line_ok;
    logic                        armed;
    logic [gef_pkg::MASK_W-1:0]  arm;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[3] == gef_pkg::REG_FALL_MASK) ? fall_mask_reg : rise_mask_reg;

    assign item.ready = !queue_full;
    assign accept     = item.valid && item.ready;

    assign arm     = item.pin_level ? rise_mask_reg : fall_mask_reg;
    assign line_ok = 32'(item.pin_index) < gef_pkg::LINE_COUNT;
    assign armed   = line_ok && arm[item.pin_index];

    always_comb
    begin
        rise_mask_next = rise_mask_reg;
        fall_mask_next = fall_mask_reg;
        usec_next      = usec_reg;
        if (cfg_write)
        begin
            if (paddr[3] == gef_pkg::REG_RISE_MASK)
            begin
                rise_mask_next = pwdata;
            end
            else
            begin
                fall_mask_next = pwdata;
            end
        end
        if (accept && item.mode == gef_pkg::MODE_TICK)
        begin
            usec_next = usec_reg + 1'b1;
        end
    end

    always_comb
    begin
        push.valid       = 1'b0;
        push.cmd.is_read = (item.mode == gef_pkg::MODE_READ);
        push.cmd.stamp   = usec_reg;
        push.cmd.line    = item.pin_index;
        push.cmd.level   = item.pin_level;
        push.cmd.count   = item.read_count;
        if (accept)
        begin
            case (item.mode)
                gef_pkg::MODE_EDGE: push.valid = armed;
                gef_pkg::MODE_READ: push.valid = 1'b1;
                default:            push.valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_mask_reg <= '0;
            fall_mask_reg <= '0;
            usec_reg      <= '0;
        end
        else
        begin
            rise_mask_reg <= rise_mask_next;
            fall_mask_reg <= fall_mask_next;
            usec_reg      <= usec_next;
        end
    end

endmodule

@@ hw/rtl/gef_cmd_queue.sv @@
// Short command queue between front end and ring back end.
module gef_cmd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gef_pkg::gef_cmd_push_t push,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output gef_pkg::gef_cmd_t      head
);

    gef_pkg::gef_cmd_t           slot_reg [gef_pkg::QUEUE_DEPTH];
    logic [gef_pkg::QPTR_W-1:0]  wr_reg, wr_next;
    logic [gef_pkg::QPTR_W-1:0]  rd_reg, rd_next;
    logic [gef_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        do_push;
    logic                        do_pop;

    assign full       = (32'(cnt_reg) == gef_pkg::QUEUE_DEPTH);
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (32'(wr_reg) == gef_pkg::QUEUE_DEPTH - 1) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (32'(rd_reg) == gef_pkg::QUEUE_DEPTH - 1) ? '0 : rd_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ hw/rtl/gef_back.sv @@
// Back end: event ring memory, burst drain and result output buffer.
module gef_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  gef_pkg::gef_cmd_t head,
    output logic              pop,
    gef_result_if.source      result
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BURST = 2'b10
    } state_t;

    state_t                       state_reg, state_next;
    gef_pkg::gef_entry_t          ring_mem [gef_pkg::RING_DEPTH];
    gef_pkg::gef_entry_t          rdata_reg;
    logic [gef_pkg::PTR_W-1:0]    wp_reg, wp_next;
    logic [gef_pkg::PTR_W-1:0]    rp_reg, rp_next;
    logic [gef_pkg::CNT_W-1:0]    remain_reg, remain_next;
    logic                         infl_reg, infl_next;
    logic                         infl_last_reg, infl_last_next;
    logic                         infl_more_reg, infl_more_next;
    gef_pkg::gef_res_t            out_reg [gef_pkg::OUT_DEPTH];
    logic                         owr_reg, owr_next;
    logic                         ord_reg, ord_next;
    logic [1:0]                   ocnt_reg, ocnt_next;

    logic [gef_pkg::PTR_W-1:0]    wp_inc;
    logic [gef_pkg::PTR_W-1:0]    rp_inc;
    logic                         ring_full;
    logic                         ring_empty;
    logic                         out_pop;
    logic                         space;
    logic                         wr_en;
    logic                         rd_en;
    logic                         out_push;
    gef_pkg::gef_res_t            push_res;
    gef_pkg::gef_res_t            head_res;
    logic [gef_pkg::CNT_W-1:0]    burst_len;
    logic                         burst_more;

    assign wp_inc     = (32'(wp_reg) == gef_pkg::RING_DEPTH - 1) ? '0 : wp_reg + 1'b1;
    assign rp_inc     = (32'(rp_reg) == gef_pkg::RING_DEPTH - 1) ? '0 : rp_reg + 1'b1;
    assign ring_full  = (wp_inc == rp_reg);
    assign ring_empty = (wp_reg == rp_reg);
    assign burst_more = (rp_inc != wp_reg);
    assign burst_len  = (32'(head.count) > gef_pkg::MAX_BURST) ?
                        gef_pkg::CNT_W'(gef_pkg::MAX_BURST) : head.count;

    assign head_res      = out_reg[ord_reg];
    assign result.valid  = (ocnt_reg != 2'd0);
    assign result.status       = head_res.status;
    assign result.stamp        = head_res.stamp;
    assign result.event_line   = head_res.line;
    assign result.edge_dir     = head_res.level;
    assign result.event_level  = head_res.level;
    assign result.last         = head_res.last;
    assign result.more_pending = head_res.more;
    assign out_pop = result.valid && result.ready;

    // room for one more word counting the read still in flight
    assign space = ((32'(ocnt_reg) + 32'(infl_reg)) < gef_pkg::OUT_DEPTH) || out_pop;

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        remain_next    = remain_reg;
        infl_next      = 1'b0;
        infl_last_next = infl_last_reg;
        infl_more_next = infl_more_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        out_push       = infl_reg;
        push_res.status = gef_pkg::STATUS_OK;
        push_res.stamp  = rdata_reg.stamp;
        push_res.line   = rdata_reg.line;
        push_res.level  = rdata_reg.level;
        push_res.last   = infl_last_reg;
        push_res.more   = infl_more_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (!head.is_read)
                    begin
                        pop = 1'b1;
                        if (!ring_full)
                        begin
                            wr_en   = 1'b1;
                            wp_next = wp_inc;
                        end
                    end
                    else if (head.count == '0 || ring_empty)
                    begin
                        if (!infl_reg && space)
                        begin
                            pop             = 1'b1;
                            out_push        = 1'b1;
                            push_res.status = (head.count == '0) ?
                                              gef_pkg::STATUS_INVALID : gef_pkg::STATUS_EMPTY;
                            push_res.stamp  = '0;
                            push_res.line   = '0;
                            push_res.level  = 1'b0;
                            push_res.last   = 1'b1;
                            push_res.more   = !ring_empty;
                        end
                    end
                    else
                    begin
                        pop         = 1'b1;
                        remain_next = burst_len;
                        state_next  = ST_BURST;
                    end
                end
            end
            ST_BURST:
            begin
                if (space)
                begin
                    rd_en          = 1'b1;
                    rp_next        = rp_inc;
                    infl_next      = 1'b1;
                    infl_more_next = burst_more;
                    infl_last_next = (remain_reg == gef_pkg::CNT_W'(1)) || !burst_more;
                    remain_next    = remain_reg - 1'b1;
                    if (infl_last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        owr_next  = owr_reg;
        ord_next  = ord_reg;
        ocnt_next = ocnt_reg;
        if (out_push)
        begin
            owr_next = !owr_reg;
        end
        if (out_pop)
        begin
            ord_next = !ord_reg;
        end
        case ({out_push, out_pop})
            2'b10:   ocnt_next = ocnt_reg + 1'b1;
            2'b01:   ocnt_next = ocnt_reg - 1'b1;
            default: ocnt_next = ocnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wp_reg] <= '{level: head.level, line: head.line, stamp: head.stamp};
        end
        if (rd_en)
        begin
            rdata_reg <= ring_mem[rp_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_reg[owr_reg] <= push_res;
        end
        infl_last_reg <= infl_last_next;
        infl_more_reg <= infl_more_next;
        remain_reg    <= remain_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            rp_reg    <= '0;
            infl_reg  <= 1'b0;
            owr_reg   <= 1'b0;
            ord_reg   <= 1'b0;
            ocnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            infl_reg  <= infl_next;
            owr_reg   <= owr_next;
            ord_reg   <= ord_next;
            ocnt_reg  <= ocnt_next;
        end
    end

endmodule

@@ hw/rtl/gpio_edge_event_fifo.sv @@
// Top level of the timestamped GPIO edge-event ring.
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+----------------------------------------------
//  item     | in  | valid/ready   | mode, pin_index, pin_level, read_count
//  result   | out | valid/ready   | status, stamp, event_line, edge_dir, ...
//  apb      | in  | psel/penable  | rise_arm_mask at 0x0, fall_arm_mask at 0x8
//
//  Ticks and edges are taken one per cycle while the two-entry command queue has room.
//  A read drains one word per cycle once started, while the receiver takes each word; the
//  registered ring read is hidden by the two-entry output buffer.
//  Edges and reads behind a read wait in the queue until its burst has been issued.
//  Reset clears pointers, counter and masks; ring contents stay undefined.
//  A stalled result holds its word and stops the drain after at most two words.
module gpio_edge_event_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    gef_item_if.sink                       item,
    gef_result_if.source                   result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gef_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gef_pkg::MASK_W-1:0]     pwdata,
    output logic [gef_pkg::MASK_W-1:0]     prdata,
    output logic                           pready
);

    gef_pkg::gef_cmd_push_t push;
    gef_pkg::gef_cmd_t      head;
    logic                   queue_full;
    logic                   head_valid;
    logic                   pop;

    gef_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .queue_full (queue_full),
        .push       (push)
    );

    gef_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    gef_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .result     (result)
    );

endmodule

@@ hw/rtl/gef_checker.sv @@
// Port-level assertions for the edge-event ring and their bind.
module gef_props (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid,
    input  logic                        ready,
    input  logic [1:0]                  status,
    input  logic [gef_pkg::STAMP_W-1:0] stamp,
    input  logic                        last,
    input  logic                        more_pending
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result valid dropped under stall");

    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(status) && $stable(stamp) && $stable(last))
        else $error("result word changed under stall");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status != gef_pkg::STATUS_OK |-> last)
        else $error("status word not marked last");

    a_more_cont: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == gef_pkg::STATUS_OK && !last |-> more_pending)
        else $error("burst continues with nothing pending");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        valid && status == gef_pkg::STATUS_EMPTY |-> !more_pending && stamp == '0)
        else $error("empty status with pending events or stamp");

endmodule

bind gpio_edge_event_fifo gef_props u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (result.valid),
    .ready        (result.ready),
    .status       (result.status),
    .stamp        (result.stamp),
    .last         (result.last),
    .more_pending (result.more_pending)
);

@@ sim/gef_checker.sv @@
// Checker for the GPIO edge-event ring: tracks masks, predicts result words and compares them.
module gef_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    gef_item_if                            item,
    gef_result_if                          result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gef_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gef_pkg::MASK_W-1:0]     pwdata,
    input  logic                           pready,
    output int                             errors,
    output int                             pending
);

    gef_pkg::gef_entry_t         ring [gef_pkg::RING_DEPTH];
    logic [gef_pkg::PTR_W-1:0]   head;
    logic [gef_pkg::PTR_W-1:0]   tail;
    logic [gef_pkg::STAMP_W-1:0] usec;
    logic [gef_pkg::MASK_W-1:0]  rise_arm;
    logic [gef_pkg::MASK_W-1:0]  fall_arm;
    gef_pkg::gef_res_t           due_words [$];
    gef_pkg::gef_res_t           want;
    int                          fail_total = 0;

    task automatic flag(input string fld, input longint unsigned exp_val,
                        input longint unsigned act_val);
        if (exp_val != act_val)
        begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, exp_val, act_val);
        end
    endtask

    task automatic predict_item(input logic [1:0] m, input logic [gef_pkg::LINE_W-1:0] pin,
                                input logic lvl, input logic [gef_pkg::CNT_W-1:0] cnt);
        logic [gef_pkg::MASK_W-1:0] arm;
        gef_pkg::gef_entry_t        ev;
        gef_pkg::gef_res_t          w;
        int                         lim;
        int                         n;
        case (m)
            gef_pkg::MODE_TICK: usec = usec + 1'b1;
            gef_pkg::MODE_EDGE:
            begin
                arm = lvl ? rise_arm : fall_arm;
                if (int'(pin) < gef_pkg::LINE_COUNT && arm[pin] &&
                    gef_pkg::PTR_W'(head + 1'b1) != tail)
                begin
                    ring[head] = '{level: lvl, line: pin, stamp: usec};
                    head = head + 1'b1;
                end
            end
            gef_pkg::MODE_READ:
            begin
                w = '0;
                w.last = 1'b1;
                if (cnt == '0)
                begin
                    w.status = gef_pkg::STATUS_INVALID;
                    w.more   = (head != tail);
                    due_words.push_back(w);
                end
                else if (head == tail)
                begin
                    w.status = gef_pkg::STATUS_EMPTY;
                    due_words.push_back(w);
                end
                else
                begin
                    lim = (int'(cnt) > gef_pkg::MAX_BURST) ? gef_pkg::MAX_BURST : int'(cnt);
                    n   = 0;
                    while (n < lim && head != tail)
                    begin
                        ev       = ring[tail];
                        tail     = tail + 1'b1;
                        w.status = gef_pkg::STATUS_OK;
                        w.stamp  = ev.stamp;
                        w.line   = ev.line;
                        w.level  = ev.level;
                        w.more   = (head != tail);
                        w.last   = (n + 1 == lim) || !w.more;
                        due_words.push_back(w);
                        n++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head     = '0;
            tail     = '0;
            usec     = '0;
            rise_arm = '0;
            fall_arm = '0;
            due_words.delete();
            pending <= 0;
            errors  <= fail_total;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {gef_pkg::REG_RISE_MASK, 3'b000})
                    rise_arm = pwdata;
                else if (paddr == {gef_pkg::REG_FALL_MASK, 3'b000})
                    fall_arm = pwdata;
            end
            if (result.valid && result.ready)
            begin
                if (due_words.size() == 0)
                begin
                    fail_total++;
                    $display("%0t: unexpected word, expected none, got status %0d stamp %0h",
                             $time, result.status, result.stamp);
                end
                else
                begin
                    want = due_words.pop_front();
                    flag("status", 64'(want.status), 64'(result.status));
                    flag("stamp", 64'(want.stamp), 64'(result.stamp));
                    flag("event_line", 64'(want.line), 64'(result.event_line));
                    flag("edge_dir", 64'(want.level), 64'(result.edge_dir));
                    flag("event_level", 64'(want.level), 64'(result.event_level));
                    flag("last", 64'(want.last), 64'(result.last));
                    flag("more_pending", 64'(want.more), 64'(result.more_pending));
                end
            end
            if (item.valid && item.ready)
                predict_item(item.mode, item.pin_index, item.pin_level, item.read_count);
            pending <= due_words.size();
            errors  <= fail_total;
        end
    end

endmodule

@@ sim/tb.sv @@
// Testbench top: drives items, result backpressure and mask writes, and reports the verdict.
module tb;

    localparam logic [1:0] MODE_RSVD  = 2'd3;
    localparam int         HOLD_LEN   = 400;
    localparam int         STALL_MAX  = 4000;
    localparam int         SETTLE_LEN = 20;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [gef_pkg::APB_ADDR_W-1:0] paddr;
    logic [gef_pkg::MASK_W-1:0]     pwdata;
    logic [gef_pkg::MASK_W-1:0]     prdata;
    logic                           pready;
    int                             errors;
    int                             pending;
    int                             src_idle  = 0;
    int                             sink_idle = 0;
    bit                             hold_sink = 0;
    int                             quiet     = 0;

    gef_item_if   item_bus ();
    gef_result_if result_bus ();

    gpio_edge_event_fifo dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gef_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .pready  (pready),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
            quiet <= 0;
        else if (quiet + 1 >= STALL_MAX)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                result_bus.ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_sink = 0;
            end
            else
                result_bus.ready <= ($urandom_range(99) >= sink_idle);
        end
    end

    task automatic send_item(input logic [1:0] m, input logic [gef_pkg::LINE_W-1:0] pin,
                             input logic lvl, input logic [gef_pkg::CNT_W-1:0] cnt);
        while ($urandom_range(99) < src_idle)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.mode       <= m;
        item_bus.pin_index  <= pin;
        item_bus.pin_level  <= lvl;
        item_bus.read_count <= cnt;
        @(posedge clk);
        while (!item_bus.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_mix(input int n);
        int                        pick;
        logic [gef_pkg::CNT_W-1:0] cnt;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_item(gef_pkg::MODE_EDGE, gef_pkg::LINE_W'($urandom), 1'($urandom),
                          gef_pkg::CNT_W'($urandom));
            else if (pick < 70)
                send_item(gef_pkg::MODE_TICK, gef_pkg::LINE_W'($urandom), 1'($urandom),
                          gef_pkg::CNT_W'($urandom));
            else if (pick < 93)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    cnt = '0;
                else if (pick < 85)
                    cnt = gef_pkg::CNT_W'($urandom_range(1, 8));
                else
                    cnt = gef_pkg::CNT_W'($urandom_range(9, 127));
                send_item(gef_pkg::MODE_READ, gef_pkg::LINE_W'($urandom), 1'($urandom), cnt);
            end
            else
                send_item(MODE_RSVD, gef_pkg::LINE_W'($urandom), 1'($urandom),
                          gef_pkg::CNT_W'($urandom));
        end
    endtask

    // drain outstanding words, then let queued edges and ticks retire
    task automatic quiesce();
        item_bus.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_LEN) @(negedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [gef_pkg::MASK_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        item_bus.valid      = 1'b0;
        item_bus.mode       = gef_pkg::MODE_TICK;
        item_bus.pin_index  = '0;
        item_bus.pin_level  = 1'b0;
        item_bus.read_count = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // masks at reset: nothing armed
        send_item(gef_pkg::MODE_READ, '0, 1'b0, 7'd0);
        send_item(gef_pkg::MODE_READ, '0, 1'b0, 7'd5);
        send_item(gef_pkg::MODE_EDGE, 6'd5, 1'b1, '0);
        send_item(gef_pkg::MODE_EDGE, 6'd5, 1'b0, '0);
        send_item(MODE_RSVD, '1, 1'b1, '1);
        quiesce();
        apb_write(gef_pkg::REG_RISE_MASK, '1);
        apb_write(gef_pkg::REG_FALL_MASK, 64'h5555_5555_5555_5555);

        send_item(gef_pkg::MODE_TICK, '0, 1'b0, '0);
        send_item(gef_pkg::MODE_TICK, '1, 1'b1, '1);
        send_item(gef_pkg::MODE_EDGE, 6'd0, 1'b1, '0);
        send_item(gef_pkg::MODE_EDGE, 6'd63, 1'b0, '0);
        send_item(gef_pkg::MODE_EDGE, 6'd62, 1'b0, '1);
        send_item(gef_pkg::MODE_TICK, '0, 1'b0, '0);
        send_item(gef_pkg::MODE_EDGE, 6'd63, 1'b1, '0);
        send_item(gef_pkg::MODE_READ, '0, 1'b0, 7'd0);
        send_item(gef_pkg::MODE_READ, '0, 1'b0, 7'd1);
        send_item(gef_pkg::MODE_READ, '1, 1'b1, 7'd127);
        send_item(gef_pkg::MODE_READ, '0, 1'b0, 7'd64);
        send_item(gef_pkg::MODE_READ, '0, 1'b0, 7'd1);
        quiesce();

        src_idle  = 35;
        sink_idle = 65;
        apb_write(gef_pkg::REG_RISE_MASK, {$urandom, $urandom});
        apb_write(gef_pkg::REG_FALL_MASK, {$urandom, $urandom});
        send_mix(100);
        quiesce();

        src_idle  = 65;
        sink_idle = 35;
        apb_write(gef_pkg::REG_RISE_MASK, '0);
        apb_write(gef_pkg::REG_FALL_MASK, '1);
        send_mix(40);
        quiesce();
        apb_write(gef_pkg::REG_RISE_MASK, {$urandom, $urandom});
        apb_write(gef_pkg::REG_FALL_MASK, {$urandom, $urandom});
        send_mix(50);
        quiesce();

        // load the ring, then drain it against a stalled receiver
        src_idle  = 0;
        sink_idle = 0;
        apb_write(gef_pkg::REG_RISE_MASK, '1);
        apb_write(gef_pkg::REG_FALL_MASK, '1);
        for (int i = 0; i < 30; i++)
            send_item((i % 16 == 15) ? gef_pkg::MODE_TICK : gef_pkg::MODE_EDGE,
                      gef_pkg::LINE_W'($urandom), 1'($urandom), gef_pkg::CNT_W'($urandom));
        send_item(gef_pkg::MODE_READ, '0, 1'b0, 7'd0);
        hold_sink = 1;
        repeat (10) send_item(gef_pkg::MODE_READ, '0, 1'b0,
                              gef_pkg::CNT_W'($urandom_range(64, 127)));
        quiesce();

        apb_write(gef_pkg::REG_RISE_MASK, 64'h8000_0000_0000_0001);
        apb_write(gef_pkg::REG_FALL_MASK, {$urandom, $urandom});
        send_mix(60);
        quiesce();

        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/gef_pkg.sv
hw/rtl/gef_if.sv
hw/rtl/gef_front.sv
hw/rtl/gef_cmd_queue.sv
hw/rtl/gef_back.sv
hw/rtl/gpio_edge_event_fifo.sv
hw/rtl/gef_checker.sv
sim/gef_checker.sv
sim/tb.sv
